// ===== hw/rtl/clsp_pkg.sv =====
// Shared types, constants and helper functions for the circle/line step point block.
package clsp_pkg;

    localparam int COORD_W   = 40;
    localparam int STEP_W    = 24;
    localparam int THR_W     = 16;
    localparam int FRAC_BITS = 24;
    localparam int DIFF_W    = COORD_W + 1;
    // Working width of the shared arithmetic unit; largest value is the root operand
    localparam int W         = 192;
    localparam int CNT_W     = $clog2(W + 1);
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Arithmetic unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef logic signed [W-1:0] clsp_wide_t;

    localparam clsp_wide_t FRAC_ONE = {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam clsp_wide_t COORD_MAX = {{(W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam clsp_wide_t COORD_MIN = {{(W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic        [STEP_W-1:0]  step_len;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        logic signed [COORD_W-1:0] next_x;
        logic signed [COORD_W-1:0] next_y;
    } clsp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      no_hit;
    } clsp_out_t;

    // Classified item as held in the queue
    typedef struct packed {
        clsp_in_t                 item;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic                     vert;
    } clsp_task_t;

    // Request to the arithmetic unit
    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } clsp_req_t;

    // Status from the arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } clsp_rsp_t;

    function automatic clsp_wide_t sx_c(input logic signed [COORD_W-1:0] v);
        return {{(W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic clsp_wide_t sx_d(input logic signed [DIFF_W-1:0] v);
        return {{(W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_c(input clsp_wide_t v);
        clsp_wide_t r;
        r = v;
        if (v > COORD_MAX) r = COORD_MAX;
        if (v < COORD_MIN) r = COORD_MIN;
        return r[COORD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/clsp_front.sv =====
// Front end: accepts input transfers, forms segment deltas and flags the vertical case.
module clsp_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clsp_pkg::clsp_in_t    s_data,
    input  logic [clsp_pkg::THR_W-1:0] thr,
    input  logic                  q_full,
    output logic                  q_push,
    output clsp_pkg::clsp_task_t  q_task
);

    logic signed [clsp_pkg::DIFF_W-1:0] dx;
    logic signed [clsp_pkg::DIFF_W-1:0] dy;
    logic        [clsp_pkg::DIFF_W-1:0] abs_dx;

    // Form deltas at full width
    always_comb begin
        dx = {s_data.next_x[clsp_pkg::COORD_W-1], s_data.next_x}
           - {s_data.prev_x[clsp_pkg::COORD_W-1], s_data.prev_x};
        dy = {s_data.next_y[clsp_pkg::COORD_W-1], s_data.next_y}
           - {s_data.prev_y[clsp_pkg::COORD_W-1], s_data.prev_y};
        abs_dx = dx[clsp_pkg::DIFF_W-1] ? -dx : dx;
    end

    // Classify and push into the queue
    always_comb begin
        q_task.item = s_data;
        q_task.dx   = dx;
        q_task.dy   = dy;
        q_task.vert = (dx == '0) || (abs_dx < clsp_pkg::DIFF_W'(thr));
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

// ===== hw/rtl/clsp_queue.sv =====
// Short queue of classified items between the front and back ends.
module clsp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  clsp_pkg::clsp_task_t din,
    output logic                 full,
    input  logic                 pop,
    output clsp_pkg::clsp_task_t dout,
    output logic                 not_empty
);

    clsp_pkg::clsp_task_t mem_reg [clsp_pkg::QDEPTH];
    logic [clsp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [clsp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [clsp_pkg::QCNT_W-1:0] count_reg;
    logic                        push_ok;
    logic                        pop_ok;

    assign full      = (count_reg == clsp_pkg::QCNT_W'(clsp_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && not_empty;
    assign dout      = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_ok) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_ok)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push_ok && !pop_ok) count_reg <= count_reg + 1'b1;
            else if (!push_ok && pop_ok) count_reg <= count_reg - 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= clsp_pkg::QCNT_W'(clsp_pkg::QDEPTH))
        else $error("queue occupancy above depth");

    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_ok && !pop_ok) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy did not advance on push");

endmodule

// ===== hw/rtl/clsp_arith.sv =====
// Shared bit-serial unit: signed multiply, truncating signed divide, floor square root.
module clsp_arith (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  clsp_pkg::clsp_req_t  req,
    input  clsp_pkg::clsp_wide_t opa,
    input  clsp_pkg::clsp_wide_t opb,
    output clsp_pkg::clsp_rsp_t  rsp,
    output clsp_pkg::clsp_wide_t result
);

    localparam int W = clsp_pkg::W;

    logic [W-1:0]                ra_reg;
    logic [W-1:0]                rb_reg;
    logic [W-1:0]                acc_reg;
    logic                        neg_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [1:0]                  op_reg;
    logic [clsp_pkg::CNT_W-1:0]  cnt_reg;
    clsp_pkg::clsp_wide_t        result_reg;

    logic [W-1:0] abs_a;
    logic [W-1:0] abs_b;
    logic [W-1:0] rem_sh;
    logic [W-1:0] trial;

    always_comb begin
        abs_a  = opa[W-1] ? W'(-opa) : W'(opa);
        abs_b  = opb[W-1] ? W'(-opb) : W'(opb);
        rem_sh = {acc_reg[W-2:0], ra_reg[W-1]};
        trial  = acc_reg + rb_reg;
    end

    // Load an operation, then step one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    op_reg   <= req.op;
                    neg_reg  <= opa[W-1] ^ opb[W-1];
                    acc_reg  <= '0;
                    case (req.op)
                        clsp_pkg::OP_MUL: begin
                            ra_reg  <= abs_a;
                            rb_reg  <= abs_b;
                            cnt_reg <= '0;
                        end
                        clsp_pkg::OP_DIV: begin
                            ra_reg  <= abs_a;
                            rb_reg  <= abs_b;
                            cnt_reg <= clsp_pkg::CNT_W'(W);
                        end
                        clsp_pkg::OP_SQRT: begin
                            ra_reg  <= W'(opa);
                            rb_reg  <= {2'b01, {(W-2){1'b0}}};
                            cnt_reg <= clsp_pkg::CNT_W'(W / 2);
                        end
                        default: begin
                            ra_reg  <= '0;
                            rb_reg  <= '0;
                            cnt_reg <= '0;
                        end
                    endcase
                end
            end else begin
                case (op_reg)
                    clsp_pkg::OP_MUL: begin
                        if (rb_reg == '0) begin
                            busy_reg   <= 1'b0;
                            done_reg   <= 1'b1;
                            result_reg <= neg_reg ? clsp_pkg::clsp_wide_t'(-acc_reg)
                                                  : clsp_pkg::clsp_wide_t'(acc_reg);
                        end else begin
                            if (rb_reg[0]) acc_reg <= acc_reg + ra_reg;
                            ra_reg <= {ra_reg[W-2:0], 1'b0};
                            rb_reg <= {1'b0, rb_reg[W-1:1]};
                        end
                    end
                    clsp_pkg::OP_DIV: begin
                        if (cnt_reg == '0) begin
                            busy_reg   <= 1'b0;
                            done_reg   <= 1'b1;
                            result_reg <= neg_reg ? clsp_pkg::clsp_wide_t'(-ra_reg)
                                                  : clsp_pkg::clsp_wide_t'(ra_reg);
                        end else begin
                            cnt_reg <= cnt_reg - 1'b1;
                            if (rem_sh >= rb_reg) begin
                                acc_reg <= rem_sh - rb_reg;
                                ra_reg  <= {ra_reg[W-2:0], 1'b1};
                            end else begin
                                acc_reg <= rem_sh;
                                ra_reg  <= {ra_reg[W-2:0], 1'b0};
                            end
                        end
                    end
                    clsp_pkg::OP_SQRT: begin
                        if (cnt_reg == '0) begin
                            busy_reg   <= 1'b0;
                            done_reg   <= 1'b1;
                            result_reg <= clsp_pkg::clsp_wide_t'(acc_reg);
                        end else begin
                            cnt_reg <= cnt_reg - 1'b1;
                            if (ra_reg >= trial) begin
                                ra_reg  <= ra_reg - trial;
                                acc_reg <= {1'b0, acc_reg[W-1:1]} + rb_reg;
                            end else begin
                                acc_reg <= {1'b0, acc_reg[W-1:1]};
                            end
                            rb_reg <= {2'b00, rb_reg[W-1:2]};
                        end
                    end
                    default: begin
                        busy_reg   <= 1'b0;
                        done_reg   <= 1'b1;
                        result_reg <= '0;
                    end
                endcase
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = result_reg;

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("arith done while still busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("arith did not take a start request");

endmodule

// ===== hw/rtl/clsp_back.sv =====
// Back end: sequences the geometry through the shared unit and holds the result transfer.
module clsp_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [clsp_pkg::THR_W-1:0] thr,
    input  logic                       q_valid,
    input  clsp_pkg::clsp_task_t       q_task,
    output logic                       q_pop,
    output clsp_pkg::clsp_req_t        a_req,
    output clsp_pkg::clsp_wide_t       a_opa,
    output clsp_pkg::clsp_wide_t       a_opb,
    input  clsp_pkg::clsp_rsp_t        a_rsp,
    input  clsp_pkg::clsp_wide_t       a_res,
    output logic                       m_valid,
    input  logic                       m_ready,
    output clsp_pkg::clsp_out_t        m_data
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_V_RR   = 5'd1;
    localparam logic [4:0] ST_V_Q    = 5'd2;
    localparam logic [4:0] ST_V_SQ   = 5'd3;
    localparam logic [4:0] ST_G_M1   = 5'd6;
    localparam logic [4:0] ST_G_M2   = 5'd7;
    localparam logic [4:0] ST_G_DX2  = 5'd8;
    localparam logic [4:0] ST_G_DY2  = 5'd9;
    localparam logic [4:0] ST_G_RR   = 5'd10;
    localparam logic [4:0] ST_G_A1   = 5'd11;
    localparam logic [4:0] ST_G_EE   = 5'd12;
    localparam logic [4:0] ST_G_A2   = 5'd13;
    localparam logic [4:0] ST_G_DYE  = 5'd14;
    localparam logic [4:0] ST_G_PYDX = 5'd15;
    localparam logic [4:0] ST_G_THR  = 5'd16;
    localparam logic [4:0] ST_S_DIV  = 5'd17;
    localparam logic [4:0] ST_T_SQ   = 5'd18;
    localparam logic [4:0] ST_T_MT   = 5'd19;
    localparam logic [4:0] ST_T_DIV  = 5'd20;
    localparam logic [4:0] ST_LY_M   = 5'd21;
    localparam logic [4:0] ST_LY_D   = 5'd22;
    localparam logic [4:0] ST_DS_X   = 5'd23;
    localparam logic [4:0] ST_DS_Y   = 5'd24;
    localparam logic [4:0] ST_FIN    = 5'd25;

    localparam int F = clsp_pkg::FRAC_BITS;

    logic [4:0]           state_reg;
    logic                 issued_reg;
    logic                 miss_reg;
    logic                 two_reg;
    logic                 pass_reg;
    logic                 m_valid_reg;
    clsp_pkg::clsp_out_t  m_data_reg;
    clsp_pkg::clsp_task_t task_reg;

    clsp_pkg::clsp_wide_t rr_reg, tmp_reg, e_reg, l2_reg, dx2_reg, d_reg, mid_reg;
    clsp_pkg::clsp_wide_t pydx_reg, s_reg, x_reg, y_reg, x1_reg, y1_reg, dist1_reg;

    clsp_pkg::clsp_wide_t r_w, cx_w, cy_w, px_w, py_w, nx_w, ny_w, dx_w, dy_w;
    clsp_pkg::clsp_wide_t h_w, abs_h, abs_dx, lo_w, hi_w, dist_w;
    clsp_pkg::clsp_wide_t yp_num, ym_num, yp_w, ym_w;
    logic                 computing;

    // Widen the held item
    always_comb begin
        r_w    = {{(clsp_pkg::W-clsp_pkg::STEP_W){1'b0}}, task_reg.item.step_len};
        cx_w   = clsp_pkg::sx_c(task_reg.item.cur_x);
        cy_w   = clsp_pkg::sx_c(task_reg.item.cur_y);
        px_w   = clsp_pkg::sx_c(task_reg.item.prev_x);
        py_w   = clsp_pkg::sx_c(task_reg.item.prev_y);
        nx_w   = clsp_pkg::sx_c(task_reg.item.next_x);
        ny_w   = clsp_pkg::sx_c(task_reg.item.next_y);
        dx_w   = clsp_pkg::sx_d(task_reg.dx);
        dy_w   = clsp_pkg::sx_d(task_reg.dy);
        h_w    = rr_reg - tmp_reg;
        abs_h  = h_w[clsp_pkg::W-1] ? -h_w : h_w;
        abs_dx = dx_w[clsp_pkg::W-1] ? -dx_w : dx_w;
        lo_w   = (cy_w < ny_w) ? cy_w : ny_w;
        hi_w   = (cy_w < ny_w) ? ny_w : cy_w;
        dist_w = tmp_reg + a_res;
    end

    // Vertical y candidates from the root term, truncated toward zero by shifting
    always_comb begin
        yp_num = (cy_w <<< F) + a_res;
        ym_num = (cy_w <<< F) - a_res;
        yp_w   = yp_num[clsp_pkg::W-1]
               ? ((yp_num + clsp_pkg::FRAC_ONE - clsp_pkg::clsp_wide_t'(1)) >>> F)
               : (yp_num >>> F);
        ym_w   = ym_num[clsp_pkg::W-1]
               ? ((ym_num + clsp_pkg::FRAC_ONE - clsp_pkg::clsp_wide_t'(1)) >>> F)
               : (ym_num >>> F);
    end

    assign computing = (state_reg != ST_IDLE) && (state_reg != ST_FIN);

    // Select the operation for the current step
    always_comb begin
        a_req.start = computing && !issued_reg;
        a_req.op    = clsp_pkg::OP_MUL;
        a_opa       = '0;
        a_opb       = '0;
        case (state_reg)
            ST_V_RR:   begin a_opa = r_w; a_opb = r_w; end
            ST_V_Q:    begin a_opa = nx_w - cx_w; a_opb = nx_w - cx_w; end
            ST_V_SQ:   begin a_req.op = clsp_pkg::OP_SQRT; a_opa = abs_h <<< (2 * F); end
            ST_G_M1:   begin a_opa = dx_w; a_opb = py_w - cy_w; end
            ST_G_M2:   begin a_opa = dy_w; a_opb = px_w - cx_w; end
            ST_G_DX2:  begin a_opa = dx_w; a_opb = dx_w; end
            ST_G_DY2:  begin a_opa = dy_w; a_opb = dy_w; end
            ST_G_RR:   begin a_opa = r_w; a_opb = r_w; end
            ST_G_A1:   begin a_opa = l2_reg; a_opb = rr_reg; end
            ST_G_EE:   begin a_opa = e_reg; a_opb = e_reg; end
            ST_G_A2:   begin a_opa = cx_w; a_opb = l2_reg; end
            ST_G_DYE:  begin a_opa = dy_w; a_opb = e_reg; end
            ST_G_PYDX: begin a_opa = py_w; a_opb = dx_w; end
            ST_G_THR:  begin
                a_opa = {{(clsp_pkg::W-clsp_pkg::THR_W){1'b0}}, thr};
                a_opb = dx2_reg;
            end
            ST_S_DIV:  begin a_req.op = clsp_pkg::OP_DIV; a_opa = mid_reg; a_opb = l2_reg; end
            ST_T_SQ:   begin a_req.op = clsp_pkg::OP_SQRT; a_opa = d_reg <<< (2 * F); end
            ST_T_MT:   begin a_opa = abs_dx; a_opb = s_reg; end
            ST_T_DIV:  begin
                a_req.op = clsp_pkg::OP_DIV;
                a_opa = pass_reg ? ((mid_reg <<< F) - s_reg) : ((mid_reg <<< F) + s_reg);
                a_opb = l2_reg <<< F;
            end
            ST_LY_M:   begin a_opa = dy_w; a_opb = x_reg - px_w; end
            ST_LY_D:   begin a_req.op = clsp_pkg::OP_DIV; a_opa = pydx_reg + tmp_reg; a_opb = dx_w; end
            ST_DS_X:   begin a_opa = x_reg - nx_w; a_opb = x_reg - nx_w; end
            ST_DS_Y:   begin a_opa = y_reg - ny_w; a_opb = y_reg - ny_w; end
            default:   begin a_opa = '0; a_opb = '0; end
        endcase
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    // Sequence the steps, capture results, hold the output transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_FIN) m_valid_reg <= 1'b0;
            if (a_req.start) issued_reg <= 1'b1;
            if (a_rsp.done) issued_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        task_reg  <= q_task;
                        miss_reg  <= 1'b0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        state_reg <= q_task.vert ? ST_V_RR : ST_G_M1;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.out_x  <= clsp_pkg::sat_c(x_reg);
                        m_data_reg.out_y  <= clsp_pkg::sat_c(y_reg);
                        m_data_reg.no_hit <= miss_reg;
                        m_valid_reg       <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    if (a_rsp.done) begin
                        case (state_reg)
                            ST_V_RR:   begin rr_reg <= a_res; state_reg <= ST_V_Q; end
                            ST_V_Q:    begin tmp_reg <= a_res; state_reg <= ST_V_SQ; end
                            ST_V_SQ:   begin
                                // Take the minus root when the plus root leaves the span
                                x_reg <= nx_w;
                                y_reg <= (yp_w < lo_w || yp_w > hi_w) ? ym_w : yp_w;
                                state_reg <= ST_FIN;
                            end
                            ST_G_M1:   begin tmp_reg <= a_res; state_reg <= ST_G_M2; end
                            ST_G_M2:   begin e_reg <= tmp_reg - a_res; state_reg <= ST_G_DX2; end
                            ST_G_DX2:  begin dx2_reg <= a_res; state_reg <= ST_G_DY2; end
                            ST_G_DY2:  begin l2_reg <= dx2_reg + a_res; state_reg <= ST_G_RR; end
                            ST_G_RR:   begin rr_reg <= a_res; state_reg <= ST_G_A1; end
                            ST_G_A1:   begin tmp_reg <= a_res; state_reg <= ST_G_EE; end
                            ST_G_EE:   begin d_reg <= tmp_reg - a_res; state_reg <= ST_G_A2; end
                            ST_G_A2:   begin tmp_reg <= a_res; state_reg <= ST_G_DYE; end
                            ST_G_DYE:  begin
                                mid_reg <= tmp_reg - a_res;
                                // Drop to no-hit on a negative discriminant
                                if (d_reg[clsp_pkg::W-1]) begin
                                    miss_reg  <= 1'b1;
                                    state_reg <= ST_FIN;
                                end else begin
                                    state_reg <= ST_G_PYDX;
                                end
                            end
                            ST_G_PYDX: begin pydx_reg <= a_res; state_reg <= ST_G_THR; end
                            ST_G_THR:  begin
                                pass_reg <= 1'b0;
                                if ((d_reg <<< 2) < a_res) begin
                                    two_reg   <= 1'b0;
                                    state_reg <= ST_S_DIV;
                                end else begin
                                    two_reg   <= 1'b1;
                                    state_reg <= ST_T_SQ;
                                end
                            end
                            ST_S_DIV:  begin x_reg <= a_res; state_reg <= ST_LY_M; end
                            ST_T_SQ:   begin s_reg <= a_res; state_reg <= ST_T_MT; end
                            ST_T_MT:   begin s_reg <= a_res; state_reg <= ST_T_DIV; end
                            ST_T_DIV:  begin x_reg <= a_res; state_reg <= ST_LY_M; end
                            ST_LY_M:   begin tmp_reg <= a_res; state_reg <= ST_LY_D; end
                            ST_LY_D:   begin
                                y_reg     <= a_res;
                                state_reg <= two_reg ? ST_DS_X : ST_FIN;
                            end
                            ST_DS_X:   begin tmp_reg <= a_res; state_reg <= ST_DS_Y; end
                            ST_DS_Y:   begin
                                if (!pass_reg) begin
                                    x1_reg    <= x_reg;
                                    y1_reg    <= y_reg;
                                    dist1_reg <= dist_w;
                                    pass_reg  <= 1'b1;
                                    state_reg <= ST_T_DIV;
                                end else begin
                                    // Plus root wins only when strictly nearer
                                    if (dist1_reg < dist_w) begin
                                        x_reg <= x1_reg;
                                        y_reg <= y1_reg;
                                    end
                                    state_reg <= ST_FIN;
                                end
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_idle_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_FIN) |-> !a_req.start)
        else $error("arith started outside a compute step");

endmodule

// ===== hw/rtl/circle_line_step_point_top.sv =====
// Top level of the circle/line step point block: config register, front, queue, back, arith.
//
//  channel  | ports                       | moves
//  ---------+-----------------------------+---------------------------------
//  input    | s_valid s_ready s_data      | step length, current point, segment
//  result   | m_valid m_ready m_data      | found point and no-hit flag
//  config   | cfg_we cfg_wdata            | near threshold (reset 1)
//
// The back end runs one step per operation of the shared one-bit-a-cycle unit: a multiply
// step ends when the bits of its second operand run out, a divide runs over the full
// working width and a root over half of it. A vertical segment takes two multiplies and a root;
// otherwise a no-hit item stops after the discriminant, and a two-root item takes the most steps.
// The input side keeps taking transfers until the 4-entry queue is full; a waiting result
// holds the back end in its finish step. Reset is synchronous and active low.
module circle_line_step_point_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  clsp_pkg::clsp_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output clsp_pkg::clsp_out_t         m_data,
    input  logic                        cfg_we,
    input  logic [clsp_pkg::THR_W-1:0]  cfg_wdata
);

    logic [clsp_pkg::THR_W-1:0] thr_reg;
    logic                       q_full;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_valid;
    clsp_pkg::clsp_task_t       q_in;
    clsp_pkg::clsp_task_t       q_out;
    clsp_pkg::clsp_req_t        a_req;
    clsp_pkg::clsp_rsp_t        a_rsp;
    clsp_pkg::clsp_wide_t       a_opa;
    clsp_pkg::clsp_wide_t       a_opb;
    clsp_pkg::clsp_wide_t       a_res;

    // Hold the threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= clsp_pkg::THR_W'(1);
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    clsp_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .thr     (thr_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_task  (q_in)
    );

    clsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .dout      (q_out),
        .not_empty (q_valid)
    );

    clsp_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (a_req),
        .opa     (a_opa),
        .opb     (a_opb),
        .rsp     (a_rsp),
        .result  (a_res)
    );

    clsp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .thr     (thr_reg),
        .q_valid (q_valid),
        .q_task  (q_out),
        .q_pop   (q_pop),
        .a_req   (a_req),
        .a_opa   (a_opa),
        .a_opb   (a_opb),
        .a_rsp   (a_rsp),
        .a_res   (a_res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
